/* design/vfd_pkg.sv */
// ----------------------------------------------------------------------------
// vfd_pkg
// Shared types, constants and helper functions for the display scanner.
// ----------------------------------------------------------------------------
package vfd_pkg;

	// number of grids that are scanned (1 to 12)
	localparam int GRID_COUNT = 12;

	// fixed field widths
	localparam int POS_W   = 4;
	localparam int DIGIT_W = 5;
	localparam int SEG_W   = 8;
	localparam int GRID_W  = 12;
	localparam int WORD_W  = 24;

	// index width into the segment store
	localparam int IDX_W = (GRID_COUNT > 1) ? $clog2(GRID_COUNT) : 1;

	localparam logic [POS_W-1:0] GRID_LIMIT = POS_W'(GRID_COUNT);
	localparam logic [POS_W-1:0] LAST_POS   = POS_W'(GRID_COUNT - 1);

	// special digit codes and their segment patterns
	localparam logic [DIGIT_W-1:0] DOT_CODE   = 5'd31;
	localparam logic [DIGIT_W-1:0] MINUS_CODE = 5'd30;
	localparam logic [SEG_W-1:0]   DOT_SEG    = 8'h01;
	localparam logic [SEG_W-1:0]   MINUS_SEG  = 8'h20;

	// segment patterns for digits 0 to 9
	localparam logic [SEG_W-1:0] DIGIT_SEGMENTS [10] = '{
		8'hDE, 8'h06, 8'hEC, 8'hAE, 8'h36, 8'hBA, 8'hFA, 8'h0E, 8'hFE, 8'hBE
	};

	typedef enum logic [1:0] {
		CMD_DIGIT   = 2'd0,
		CMD_RAW     = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_REFRESH = 2'd3
	} cmd_t;

	// one command beat held in the input register
	typedef struct packed {
		cmd_t                       cmd;
		logic [POS_W-1:0]           position;
		logic signed [DIGIT_W-1:0]  digit;
		logic [SEG_W-1:0]           raw_segments;
	} cmd_beat_t;

	// write/clear request toward the segment store
	typedef struct packed {
		logic              wr_en;
		logic              clr;
		logic [IDX_W-1:0]  wr_idx;
		logic [SEG_W-1:0]  wr_data;
	} store_op_t;

	// digit code to segment byte; unknown codes blank the position
	function automatic logic [SEG_W-1:0] decode_digit(input logic [DIGIT_W-1:0] code);
		logic [SEG_W-1:0] seg;
		seg = '0;
		if (code <= 5'd9) begin
			seg = DIGIT_SEGMENTS[code[3:0]];
		end else if (code == DOT_CODE) begin
			seg = DOT_SEG;
		end else if (code == MINUS_CODE) begin
			seg = MINUS_SEG;
		end
		return seg;
	endfunction

	// driver chain layout, first shifted byte on top
	function automatic logic [WORD_W-1:0] pack_word(input logic [GRID_W-1:0] grids,
			input logic [SEG_W-1:0] segs);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		b0 = {4'b0000, grids[0], grids[1], segs[7:6]};
		b1 = {segs[5:0], grids[11:10]};
		b2 = grids[9:2];
		return {b0, b1, b2};
	endfunction

endpackage

/* design/vfd_if.sv */
// ----------------------------------------------------------------------------
// vfd_if
// Handshake channels of the scanner: command input and driver word output.
// ----------------------------------------------------------------------------
interface vfd_cmd_if;
	import vfd_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [1:0]                cmd;
	logic [POS_W-1:0]          position;
	logic signed [DIGIT_W-1:0] digit;
	logic [SEG_W-1:0]          raw_segments;

	modport source (output valid, output cmd, output position, output digit,
		output raw_segments, input ready);
	modport sink (input valid, input cmd, input position, input digit,
		input raw_segments, output ready);
endinterface

interface vfd_word_if;
	import vfd_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] shift_word;
	logic [POS_W-1:0]  grid_index;

	modport source (output valid, output shift_word, output grid_index, input ready);
	modport sink (input valid, input shift_word, input grid_index, output ready);
endinterface

/* design/vfd_in_stage.sv */
// ----------------------------------------------------------------------------
// vfd_in_stage
// Input register: captures one command beat and holds it until it is taken.
// ----------------------------------------------------------------------------
module vfd_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	vfd_cmd_if.sink            command,
	input  logic               take_s1,
	output logic               valid_s1,
	output vfd_pkg::cmd_beat_t beat_s1
);
	import vfd_pkg::*;

	logic      accept;
	cmd_beat_t beat_in;

	// room when empty or when the held beat leaves this cycle
	assign command.ready = !valid_s1 || take_s1;
	assign accept        = command.valid && command.ready;

	assign beat_in.cmd          = cmd_t'(command.cmd);
	assign beat_in.position     = command.position;
	assign beat_in.digit        = command.digit;
	assign beat_in.raw_segments = command.raw_segments;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (command.ready) begin
			valid_s1 <= command.valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1 <= beat_in;
		end
	end

endmodule

/* design/vfd_seg_store.sv */
// ----------------------------------------------------------------------------
// vfd_seg_store
// Segment memory: one byte per grid, single write, bulk clear, one read port.
// ----------------------------------------------------------------------------
module vfd_seg_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vfd_pkg::store_op_t            op,
	input  logic [vfd_pkg::IDX_W-1:0]     rd_idx,
	output logic [vfd_pkg::SEG_W-1:0]     rd_data
);
	import vfd_pkg::*;

	logic [SEG_W-1:0] seg_q [GRID_COUNT];

	// clear wins over a write; a cleared entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GRID_COUNT; i++) begin
				seg_q[i] <= '0;
			end
		end else if (op.clr) begin
			for (int i = 0; i < GRID_COUNT; i++) begin
				seg_q[i] <= '0;
			end
		end else if (op.wr_en) begin
			seg_q[op.wr_idx] <= op.wr_data;
		end
	end

	// read of the entry under scan
	assign rd_data = seg_q[rd_idx];

endmodule

/* design/vfd_out_stage.sv */
// ----------------------------------------------------------------------------
// vfd_out_stage
// Scan position counter, word packing and the result register.
// ----------------------------------------------------------------------------
module vfd_out_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       refresh_go,
	input  logic [vfd_pkg::SEG_W-1:0]  seg_data,
	output logic [vfd_pkg::IDX_W-1:0]  scan_idx,
	output logic                       out_free,
	vfd_word_if.source                 word
);
	import vfd_pkg::*;

	logic [POS_W-1:0]  scan_q;
	logic [POS_W-1:0]  cur_pos;
	logic [POS_W-1:0]  next_pos;
	logic [GRID_W-1:0] grids;
	logic              valid_q;
	logic [WORD_W-1:0] shift_word_q;
	logic [POS_W-1:0]  grid_index_q;

	// a stray position restarts the scan at zero
	assign cur_pos  = (scan_q >= GRID_LIMIT) ? '0 : scan_q;
	assign next_pos = (cur_pos == LAST_POS) ? '0 : cur_pos + 1'b1;
	assign scan_idx = cur_pos[IDX_W-1:0];
	assign grids    = GRID_W'(1) << cur_pos;

	// the result register can take a word this cycle
	assign out_free = !valid_q || word.ready;

	// scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (refresh_go) begin
			scan_q <= next_pos;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= refresh_go;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (refresh_go) begin
			shift_word_q <= pack_word(grids, seg_data);
			grid_index_q <= cur_pos;
		end
	end

	assign word.valid      = valid_q;
	assign word.shift_word = shift_word_q;
	assign word.grid_index = grid_index_q;

endmodule

/* design/vfd_multiplex_scanner.sv */
// ----------------------------------------------------------------------------
// vfd_multiplex_scanner
// Scanner for a 12-grid multiplexed display: segment memory writes and
// clears, and one 24-bit driver word per refresh tick.
// ----------------------------------------------------------------------------
//   channel   dir   beat                                   result
//   command   in    cmd, position, digit, raw_segments     refresh only
//   word      out   shift_word, grid_index                 one per refresh
//
// One command is taken every cycle unless a refresh stalls the input register;
// a refresh word passes the input register, then the result register.
// Reset clears the segment memory, the scan position and both valid flags.
// A stalled word holds the result register; a refresh waiting behind it
// stalls the input register, while writes and clears keep flowing until a
// refresh reaches the input register.
// ----------------------------------------------------------------------------
module vfd_multiplex_scanner (
	input  logic        clk,
	input  logic        arst_n,
	vfd_cmd_if.sink     command,
	vfd_word_if.source  word
);
	import vfd_pkg::*;

	logic             valid_s1;
	cmd_beat_t        beat_s1;
	logic             take_s1;
	logic             is_refresh;
	logic             refresh_go;
	logic             out_free;
	logic             pos_ok;
	store_op_t        op;
	logic [IDX_W-1:0] scan_idx;
	logic [SEG_W-1:0] seg_data;
	logic [SEG_W-1:0] wr_data;

	vfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.command  (command),
		.take_s1  (take_s1),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	// the held beat leaves unless a refresh waits on a full result register
	assign is_refresh = (beat_s1.cmd == CMD_REFRESH);
	assign take_s1    = valid_s1 && (!is_refresh || out_free);
	assign refresh_go = take_s1 && is_refresh;
	assign pos_ok     = (beat_s1.position < GRID_LIMIT);

	// write data by command
	always_comb begin
		case (beat_s1.cmd)
			CMD_DIGIT: wr_data = decode_digit(beat_s1.digit);
			CMD_RAW:   wr_data = beat_s1.raw_segments;
			default:   wr_data = '0;
		endcase
	end

	// store request
	always_comb begin
		op.wr_en   = take_s1 && pos_ok &&
			(beat_s1.cmd == CMD_DIGIT || beat_s1.cmd == CMD_RAW);
		op.clr     = take_s1 && (beat_s1.cmd == CMD_CLEAR);
		op.wr_idx  = beat_s1.position[IDX_W-1:0];
		op.wr_data = wr_data;
	end

	vfd_seg_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op),
		.rd_idx  (scan_idx),
		.rd_data (seg_data)
	);

	vfd_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.refresh_go (refresh_go),
		.seg_data   (seg_data),
		.scan_idx   (scan_idx),
		.out_free   (out_free),
		.word       (word)
	);

`ifndef SYNTHESIS
	// a refresh that leaves the input register shows up as a word
	a_refresh_word: assert property (@(posedge clk) disable iff (!arst_n)
		refresh_go |=> word.valid)
		else $error("refresh did not produce a word");

	// a shown word lights a grid that exists
	a_grid_range: assert property (@(posedge clk) disable iff (!arst_n)
		word.valid |-> (word.grid_index < GRID_LIMIT))
		else $error("grid index out of range");

	// exactly one grid select bit is set in a shown word
	a_grid_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		word.valid |-> $onehot({word.shift_word[19:18], word.shift_word[9:0]}))
		else $error("grid select is not one-hot");

	// a refresh never leaves while a stalled word still waits
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(word.valid && !word.ready) |-> !refresh_go)
		else $error("refresh overran a stalled word");
`endif

endmodule
